/* hw/rtl/ctov_pkg.sv */
`timescale 1ns / 1ps

package ctov_pkg;

  localparam int COORD_BITS_DEF = 18;
  localparam int RADIUS_W       = 16;
  localparam int R2_W           = 2 * RADIUS_W;
  localparam int DATA_W         = 32;
  localparam int PADDR_W        = 3;
  localparam int DIGIT_W        = 16;
  localparam int STAGES         = 6;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1918;
  localparam logic [R2_W-1:0]     R2_RESET     = R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);

  // register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_RADIUS = '0;

  typedef struct packed {
    logic vhit;
    logic cr_pos;
    logic cr_neg;
    logic dot_ok;
  } edge_stat_t;

endpackage

/* hw/rtl/ctov_edge.sv */
`timescale 1ns / 1ps

module ctov_edge #(
  parameter int COORD_BITS = ctov_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en1,
  input  logic                           en2,
  input  logic                           en3,
  input  logic signed [COORD_BITS-1:0]   p_x,
  input  logic signed [COORD_BITS-1:0]   p_y,
  input  logic signed [COORD_BITS-1:0]   s_x,
  input  logic signed [COORD_BITS-1:0]   s_y,
  input  logic signed [COORD_BITS-1:0]   e_x,
  input  logic signed [COORD_BITS-1:0]   e_y,
  input  logic [ctov_pkg::R2_W-1:0]      r2,
  output ctov_pkg::edge_stat_t           stat,
  output logic [2*COORD_BITS:0]          crm,
  output logic [2*COORD_BITS:0]          ee
);
  import ctov_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int CW   = 2 * COORD_BITS + 1;
  localparam int CMPW = (CW > R2_W) ? CW : R2_W;

  // stage 1: offsets from the edge start
  logic signed [DW-1:0] cx_r, cy_r, ex_r, ey_r;
  logic signed [DW-1:0] cx_nxt, cy_nxt, ex_nxt, ey_nxt;

  // stage 2: products
  logic signed [PW-1:0] cxx_r, cyy_r, cxex_r, cyey_r, exx_r, eyy_r, cxey_r, cyex_r;
  logic signed [PW-1:0] cxx_nxt, cyy_nxt, cxex_nxt, cyey_nxt;
  logic signed [PW-1:0] exx_nxt, eyy_nxt, cxey_nxt, cyex_nxt;

  // stage 3: sums, signs and magnitudes
  edge_stat_t    stat_r, stat_nxt;
  logic [CW-1:0] crm_r, crm_nxt;
  logic [CW-1:0] ee_r, ee_nxt;

  logic signed [PW-1:0] cc_s, ee_s, dot_s, cross_s;
  logic signed [PW:0]   gap_s;
  logic [CW-1:0]        cc_u;

  always_comb begin
    cx_nxt = DW'(p_x) - DW'(s_x);
    cy_nxt = DW'(p_y) - DW'(s_y);
    ex_nxt = DW'(e_x) - DW'(s_x);
    ey_nxt = DW'(e_y) - DW'(s_y);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
    end
  end

  always_comb begin
    cxx_nxt  = PW'(cx_r) * PW'(cx_r);
    cyy_nxt  = PW'(cy_r) * PW'(cy_r);
    cxex_nxt = PW'(cx_r) * PW'(ex_r);
    cyey_nxt = PW'(cy_r) * PW'(ey_r);
    exx_nxt  = PW'(ex_r) * PW'(ex_r);
    eyy_nxt  = PW'(ey_r) * PW'(ey_r);
    cxey_nxt = PW'(cx_r) * PW'(ey_r);
    cyex_nxt = PW'(cy_r) * PW'(ex_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cxx_r  <= cxx_nxt;
      cyy_r  <= cyy_nxt;
      cxex_r <= cxex_nxt;
      cyey_r <= cyey_nxt;
      exx_r  <= exx_nxt;
      eyy_r  <= eyy_nxt;
      cxey_r <= cxey_nxt;
      cyex_r <= cyex_nxt;
    end
  end

  // |c|^2|e|^2 - dot^2 equals cross^2, so only |cross| goes on
  always_comb begin
    cc_s    = cxx_r + cyy_r;
    ee_s    = exx_r + eyy_r;
    dot_s   = cxex_r + cyey_r;
    cross_s = cxey_r - cyex_r;
    gap_s   = (PW+1)'(ee_s) - (PW+1)'(dot_s);
    cc_u    = CW'(cc_s);

    stat_nxt.vhit   = CMPW'(cc_u) <= CMPW'(r2);
    stat_nxt.cr_pos = !cross_s[PW-1] && (cross_s != '0);
    stat_nxt.cr_neg = cross_s[PW-1];
    stat_nxt.dot_ok = !dot_s[PW-1] && (dot_s != '0) && !gap_s[PW] && (gap_s != '0);

    crm_nxt = cross_s[PW-1] ? CW'(-cross_s) : CW'(cross_s);
    ee_nxt  = CW'(ee_s);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      stat_r <= stat_nxt;
      crm_r  <= crm_nxt;
      ee_r   <= ee_nxt;
    end
  end

  assign stat = stat_r;
  assign crm  = crm_r;
  assign ee   = ee_r;

endmodule

/* hw/rtl/ctov_mul.sv */
`timescale 1ns / 1ps

module ctov_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en_pp,
  input  logic             en_sum,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  import ctov_pkg::*;

  localparam int ND  = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int PPW = AW + DIGIT_W;
  localparam int PW  = AW + BW;

  logic [ND*DIGIT_W-1:0] b_pad;
  logic [PPW-1:0]        pp_r   [ND];
  logic [PPW-1:0]        pp_nxt [ND];
  logic [PW-1:0]         p_r, p_nxt;

  // one partial product per 16-bit digit of b
  always_comb begin
    b_pad = (ND*DIGIT_W)'(b);
    for (int k = 0; k < ND; k++) begin
      pp_nxt[k] = PPW'(a) * PPW'(b_pad[k*DIGIT_W +: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_pp) begin
      for (int k = 0; k < ND; k++) begin
        pp_r[k] <= pp_nxt[k];
      end
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int k = 0; k < ND; k++) begin
      p_nxt = p_nxt + (PW'(pp_r[k]) << (k * DIGIT_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

/* hw/rtl/circle_triangle_overlap_core.sv */
`timescale 1ns / 1ps
// Circle / triangle overlap tester.
// Input channel (in_valid/in_ready): one circle centre and three triangle
// vertices per item, signed fixed point with 16 fraction bits.
// Result channel (out_valid/out_ready): one overlap bit per item, in order.
// Config port (cfg_*, APB-style, pready tied high): register 0 at byte
// address 0 holds the 16-bit radius; the user must write it only while
// the block is empty, which the block itself does not enforce.
// Six register stages: offsets, products, sums and signs, partial products
// of the two wide squared-distance products, their sums, and the result
// register. One item per cycle is sustained while out_ready stays high;
// each stage carries its own valid bit. When the receiver stalls, the result
// register holds, and upstream stages keep filling empty slots, so in_ready
// drops only once every stage is full.
// Synchronous reset (rst_n low) empties the pipeline and sets the radius to
// 1918 (about 0.0293).
module circle_triangle_overlap_core #(
  parameter int COORD_BITS = ctov_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_BITS-1:0]    in_center_x,
  input  logic signed [COORD_BITS-1:0]    in_center_y,
  input  logic signed [COORD_BITS-1:0]    in_vert_a_x,
  input  logic signed [COORD_BITS-1:0]    in_vert_a_y,
  input  logic signed [COORD_BITS-1:0]    in_vert_b_x,
  input  logic signed [COORD_BITS-1:0]    in_vert_b_y,
  input  logic signed [COORD_BITS-1:0]    in_vert_c_x,
  input  logic signed [COORD_BITS-1:0]    in_vert_c_y,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_overlap,

  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ctov_pkg::PADDR_W-1:0]    cfg_paddr,
  input  logic [ctov_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [ctov_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import ctov_pkg::*;

  localparam int CW = 2 * COORD_BITS + 1;
  localparam int LW = (2 * CW > R2_W + CW) ? 2 * CW : R2_W + CW;

  // config
  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic [R2_W-1:0]     r2_r, r2_nxt;
  logic                cfg_wr, cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[PADDR_W-1:2] == REG_RADIUS;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;

  always_comb begin
    radius_nxt = radius_r;
    r2_nxt     = r2_r;
    if (cfg_wr) begin
      radius_nxt = cfg_pwdata[RADIUS_W-1:0];
      r2_nxt     = R2_W'(cfg_pwdata[RADIUS_W-1:0]) * R2_W'(cfg_pwdata[RADIUS_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      r2_r     <= R2_RESET;
    end else begin
      radius_r <= radius_nxt;
      r2_r     <= r2_nxt;
    end
  end

  assign cfg_prdata = cfg_hit ? DATA_W'(radius_r) : '0;

  // valid chain: a stage loads when it is empty or its successor moves
  logic [STAGES-1:0] v_r, v_nxt;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STAGES-1];

  // three edges: A->B, B->C, C->A
  logic signed [COORD_BITS-1:0] vx [3];
  logic signed [COORD_BITS-1:0] vy [3];
  edge_stat_t                   stat [3];
  logic [CW-1:0]                crm  [3];
  logic [CW-1:0]                ee   [3];
  logic [2*CW-1:0]              lhs  [3];
  logic [R2_W+CW-1:0]           rhs  [3];

  assign vx[0] = in_vert_a_x;
  assign vy[0] = in_vert_a_y;
  assign vx[1] = in_vert_b_x;
  assign vy[1] = in_vert_b_y;
  assign vx[2] = in_vert_c_x;
  assign vy[2] = in_vert_c_y;

  for (genvar i = 0; i < 3; i++) begin : g_edge
    ctov_edge #(
      .COORD_BITS (COORD_BITS)
    ) u_edge (
      .clk  (clk),
      .en1  (rdy[0]),
      .en2  (rdy[1]),
      .en3  (rdy[2]),
      .p_x  (in_center_x),
      .p_y  (in_center_y),
      .s_x  (vx[i]),
      .s_y  (vy[i]),
      .e_x  (vx[(i + 1) % 3]),
      .e_y  (vy[(i + 1) % 3]),
      .r2   (r2_r),
      .stat (stat[i]),
      .crm  (crm[i]),
      .ee   (ee[i])
    );

    ctov_mul #(
      .AW (CW),
      .BW (CW)
    ) u_lhs (
      .clk    (clk),
      .en_pp  (rdy[3]),
      .en_sum (rdy[4]),
      .a      (crm[i]),
      .b      (crm[i]),
      .p      (lhs[i])
    );

    ctov_mul #(
      .AW (R2_W),
      .BW (CW)
    ) u_rhs (
      .clk    (clk),
      .en_pp  (rdy[3]),
      .en_sum (rdy[4]),
      .a      (r2_r),
      .b      (ee[i]),
      .p      (rhs[i])
    );
  end

  // flags travel beside the multipliers
  logic       vh4_r, in4_r, vh5_r, in5_r;
  logic [2:0] dok4_r, dok5_r;
  logic       vh4_nxt, in4_nxt;
  logic [2:0] dok4_nxt, near;
  logic       out_overlap_r, out_overlap_nxt;

  always_comb begin
    vh4_nxt = stat[0].vhit || stat[1].vhit || stat[2].vhit;
    in4_nxt = !((stat[0].cr_pos || stat[1].cr_pos || stat[2].cr_pos) &&
                (stat[0].cr_neg || stat[1].cr_neg || stat[2].cr_neg));
    for (int i = 0; i < 3; i++) begin
      dok4_nxt[i] = stat[i].dot_ok;
      near[i]     = dok5_r[i] && (LW'(lhs[i]) <= LW'(rhs[i]));
    end
    out_overlap_nxt = vh5_r || in5_r || (|near);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      vh4_r  <= vh4_nxt;
      in4_r  <= in4_nxt;
      dok4_r <= dok4_nxt;
    end
    if (rdy[4]) begin
      vh5_r  <= vh4_r;
      in5_r  <= in4_r;
      dok5_r <= dok4_r;
    end
    if (rdy[5]) begin
      out_overlap_r <= out_overlap_nxt;
    end
  end

  assign out_overlap = out_overlap_r;

endmodule

/* hw/rtl/ctov_chk.sv */
`timescale 1ns / 1ps

module ctov_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_overlap,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite,
  input logic [ctov_pkg::PADDR_W-1:0] cfg_paddr,
  input logic [ctov_pkg::DATA_W-1:0]  cfg_pwdata,
  input logic [ctov_pkg::DATA_W-1:0]  cfg_prdata
);
  import ctov_pkg::*;

  logic radius_wr, radius_rd;

  assign radius_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                     (cfg_paddr[PADDR_W-1:2] == REG_RADIUS);
  assign radius_rd = cfg_psel && !cfg_pwrite && (cfg_paddr[PADDR_W-1:2] == REG_RADIUS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_overlap))
    else $error("stalled item changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item did not reach output in time");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(radius_wr) && radius_rd |->
      cfg_prdata[RADIUS_W-1:0] == $past(cfg_pwdata[RADIUS_W-1:0]))
    else $error("radius readback mismatch");

endmodule

bind circle_triangle_overlap_core ctov_chk u_ctov_chk (.*);
